[sv/assert_macros.svh]
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/gcs_pkg.sv]
`timescale 1ns / 1ps
package gcs_pkg;

    localparam int CORDIC_ITERATIONS = 32;
    localparam int CI_W = $clog2(CORDIC_ITERATIONS);

    localparam logic signed [63:0] Q60_ONE   = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] Q60_TENTH = Q60_ONE / 10;

    // angles in 1e-7 degree
    localparam logic signed [35:0] FULL_TURN    = 36'sd3600000000;
    localparam logic signed [35:0] HALF_TURN    = 36'sd1800000000;
    localparam logic signed [35:0] QUARTER_TURN = 36'sd900000000;
    localparam logic signed [35:0] EIGHTH_TURN  = 36'sd450000000;

    localparam logic [29:0] NS_PER_S     = 30'd1000000000;
    localparam logic [9:0]  MM_PER_M     = 10'd1000;
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;
    localparam logic [34:0] DIST_MAX     = {35{1'b1}};

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FIRST = 2'd1;
    localparam logic [1:0] STATUS_STALE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRAP, ST_QUAD, ST_RAD_MUL, ST_RAD_DIV, ST_ROT, ST_MQ, ST_CLAMP,
        ST_SQRT, ST_VEC, ST_DIST, ST_TIME, ST_SPD_MUL, ST_SPD_DIV, ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MQ_P0, MQ_P1, MQ_Q0, MQ_Q1, MQ_DOT0, MQ_DOT1, MQ_DOT2, MQ_SQR
    } mq_step_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    typedef logic signed [63:0] atan_tab_t [CORDIC_ITERATIONS];

    // restoring division, elaboration only
    function automatic logic [63:0] udiv_f(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            q   = {q[62:0], 1'b0};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in Q60 by its series, truncating each term
    function automatic logic signed [63:0] atan_recip_f(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] k;
        logic [63:0] t;
        logic signed [63:0] s;
        p = udiv_f(64'(Q60_ONE), n);
        k = '0;
        s = '0;
        for (int j = 0; j < 64; j++) begin
            if (p != 64'd0) begin
                t = udiv_f(p, (k << 1) + 64'd1);
                if (k[0]) s = s - $signed(t);
                else      s = s + $signed(t);
                p = udiv_f(udiv_f(p, n), n);
                k = k + 64'd1;
            end
        end
        return s;
    endfunction

    function automatic logic signed [63:0] mulq_f(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] m;
        logic [127:0] pr;
        logic signed [63:0] r;
        ua = a[63] ? 64'd0 - $unsigned(a) : $unsigned(a);
        ub = b[63] ? 64'd0 - $unsigned(b) : $unsigned(b);
        pr = {64'd0, ua} * {64'd0, ub};
        m  = (pr[127:124] != 4'd0) ? {64{1'b1}} : pr[123:60];
        if (m[63]) m = {1'b0, {63{1'b1}}};
        r = $signed(m);
        return (a[63] != b[63]) ? -r : r;
    endfunction

    localparam logic signed [63:0] PI_Q60 =
        ((atan_recip_f(64'd5) <<< 2) - atan_recip_f(64'd239)) <<< 2;
    localparam logic signed [63:0] HALF_PI_Q60 = PI_Q60 >>> 1;

    function automatic atan_tab_t atan_tab_f();
        atan_tab_t tab;
        for (int j = 0; j < CORDIC_ITERATIONS; j++) begin
            if (j == 0) tab[j] = PI_Q60 >>> 2;
            else        tab[j] = atan_recip_f(64'd1 << j);
        end
        return tab;
    endfunction

    // CORDIC gain by Newton iteration on 1/sqrt(prod)
    function automatic logic signed [63:0] gain_f();
        logic signed [63:0] prod;
        logic signed [63:0] y;
        logic signed [63:0] three;
        prod  = Q60_ONE;
        three = Q60_ONE + (Q60_ONE <<< 1);
        for (int j = 0; j < CORDIC_ITERATIONS; j++) begin
            if (2 * j < 63) prod = prod + (prod >>> (2 * j));
        end
        y = (Q60_TENTH <<< 2) + (Q60_TENTH <<< 1);
        for (int j = 0; j < 10; j++) begin
            y = mulq_f(y, three - mulq_f(prod, mulq_f(y, y))) >>> 1;
        end
        return y;
    endfunction

    localparam atan_tab_t ATAN_TAB = atan_tab_f();
    localparam logic signed [63:0] GAIN_K = gain_f();

endpackage

[sv/gcs_mul.sv]
`timescale 1ns / 1ps
module gcs_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] product
);
    logic [63:0] a_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] sum;

    // one multiplier bit per cycle, LSB first
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : 65'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= op_a;
            hi_reg <= '0;
            lo_reg <= op_b;
        end else if (busy_reg) begin
            hi_reg <= sum[64:1];
            lo_reg <= {sum[0], lo_reg[63:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};
endmodule

[sv/gcs_div.sv]
`timescale 1ns / 1ps
module gcs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [95:0] numer,
    input  logic [63:0] denom,
    output logic        done,
    output logic [95:0] quotient
);
    logic [95:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] rem_sh;
    logic [64:0] rem_diff;
    logic        fits;

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {rem_reg, num_reg[95]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign fits     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd95) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[63:0] : rem_sh[63:0];
            num_reg <= {num_reg[94:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;
endmodule

[sv/gcs_sqrt.sv]
`timescale 1ns / 1ps
module gcs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        ge;

    // two radicand bits per cycle
    assign trial = res_reg + bit_reg;
    assign ge    = v_reg >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end else if (busy_reg) begin
            v_reg   <= ge ? v_reg - trial : v_reg;
            res_reg <= ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

[sv/gcs_cordic.sv]
`timescale 1ns / 1ps
module gcs_cordic (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gcs_pkg::cordic_cmd_t      cmd,
    input  logic signed [63:0]        x0,
    input  logic signed [63:0]        y0,
    input  logic signed [63:0]        z0,
    output logic                      done,
    output logic signed [63:0]        x,
    output logic signed [63:0]        y,
    output logic signed [63:0]        z
);
    import gcs_pkg::*;

    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [63:0] z_reg;
    logic               vec_reg;
    logic [CI_W-1:0]    i_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic               d_pos;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    // rotation steers by the sign of z, vectoring drives y to zero
    assign d_pos = vec_reg ? !(y_reg > 64'sd0) : !z_reg[63];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                i_reg <= i_reg + CI_W'(1);
                if (i_reg == CI_W'(CORDIC_ITERATIONS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
            vec_reg <= cmd.vectoring;
        end else if (busy_reg) begin
            x_reg <= d_pos ? x_reg - ys : x_reg + ys;
            y_reg <= d_pos ? y_reg + xs : y_reg - xs;
            z_reg <= d_pos ? z_reg - ATAN_TAB[i_reg] : z_reg + ATAN_TAB[i_reg];
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
endmodule

[sv/gps_great_circle_speed_unit.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Great-circle distance and average speed between consecutive GPS fixes by the spherical
// law of cosines, in Q60 fixed point. A first fix is answered without any arithmetic: it
// goes straight to the finish state and is loaded into the output register once that has
// room. Every later fix runs four angle conversions (wrap and quadrant split, a serial
// multiply, a serial divide, a CORDIC rotation), eight signed Q60 products on the same
// multiplier, a square root, a CORDIC vectoring pass, the distance product, and the speed
// product and division, which are skipped when time does not advance. One fix is
// processed at a time; the next may be taken while the previous result waits in the
// output register.
module gps_great_circle_speed_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [30:0] s_latitude,
    input  logic [31:0] s_longitude,
    input  logic [62:0] s_timestamp_ns,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [34:0] m_distance_mm,
    output logic [31:0] m_speed_mm_per_s,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_sphere_radius_m
);
    import gcs_pkg::*;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   have_prev_reg, have_prev_next;
    logic   m_valid_reg, m_valid_next;
    logic [23:0] radius_reg;
    logic   out_load;

    logic signed [30:0] cur_lat_reg, cur_lat_next, prev_lat_reg;
    logic signed [31:0] cur_lon_reg, cur_lon_next, prev_lon_reg;
    logic [62:0] cur_time_reg, cur_time_next, prev_time_reg;
    logic [1:0]  ang_idx_reg, ang_idx_next;
    logic [32:0] trem_reg, trem_next;
    logic [2:0]  qd_reg, qd_next;
    logic [28:0] m_reg, m_next;
    logic        esign_reg, esign_next;
    logic signed [63:0] cos_reg [4];
    logic signed [63:0] cos_next [4];
    logic signed [63:0] sin_reg [4];
    logic signed [63:0] sin_next [4];
    logic signed [63:0] vp0_reg, vp0_next, vp1_reg, vp1_next;
    logic signed [63:0] vq0_reg, vq0_next, vq1_reg, vq1_next;
    logic signed [63:0] dot_reg, dot_next;
    logic signed [63:0] acos_c_reg, acos_c_next;
    logic signed [63:0] cc_reg, cc_next;
    logic signed [63:0] theta_reg, theta_next;
    mq_step_t    mq_reg, mq_next;
    logic [1:0]  status_reg, status_next;
    logic [34:0] dist_reg, dist_next;
    logic [31:0] speed_reg, speed_next;
    logic [1:0]  m_status_reg;
    logic [34:0] m_dist_reg;
    logic [31:0] m_speed_reg;

    logic         mul_start, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_prod;
    logic         div_start, div_done;
    logic [95:0]  div_num, div_quot;
    logic [63:0]  div_den;
    logic         sqrt_start, sqrt_done;
    logic [63:0]  sqrt_in;
    logic [31:0]  sqrt_root;
    cordic_cmd_t  cor_cmd;
    logic signed [63:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
    logic         cor_done;

    logic signed [35:0] ang_d, ang_r, ang_t, ang_e, ang_e_abs;
    logic signed [63:0] rad_q, mq_a, mq_b, mq_res, s_val;
    logic [63:0]  mq_ua, mq_ub, mq_mag;
    logic [127:0] dist_sum;
    logic [33:0]  radius_mm;
    logic [62:0]  elapsed;

    gcs_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
        .done(mul_done), .product(mul_prod)
    );
    gcs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(div_num),
        .denom(div_den), .done(div_done), .quotient(div_quot)
    );
    gcs_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start), .radicand(sqrt_in),
        .done(sqrt_done), .root(sqrt_root)
    );
    gcs_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .cmd(cor_cmd), .x0(cor_x0), .y0(cor_y0),
        .z0(cor_z0), .done(cor_done), .x(cor_x), .y(cor_y), .z(cor_z)
    );

    // wrap to (-180, 180] and offset by an eighth turn for the quadrant split
    always_comb begin
        case (ang_idx_reg)
            2'd0:    ang_d = 36'(cur_lat_reg);
            2'd1:    ang_d = 36'(cur_lon_reg);
            2'd2:    ang_d = 36'(prev_lat_reg);
            default: ang_d = 36'(prev_lon_reg);
        endcase
        if (ang_d > HALF_TURN)        ang_r = ang_d - FULL_TURN;
        else if (ang_d <= -HALF_TURN) ang_r = ang_d + FULL_TURN;
        else                          ang_r = ang_d;
        ang_t     = ang_r + EIGHTH_TURN + FULL_TURN;
        ang_e     = $signed({3'b000, trem_reg}) - EIGHTH_TURN;
        ang_e_abs = ang_e[35] ? -ang_e : ang_e;
    end

    // signed Q60 product around the unsigned serial multiplier
    always_comb begin
        case (mq_reg)
            MQ_P0:   begin mq_a = cos_reg[0]; mq_b = cos_reg[1]; end
            MQ_P1:   begin mq_a = cos_reg[0]; mq_b = sin_reg[1]; end
            MQ_Q0:   begin mq_a = cos_reg[2]; mq_b = cos_reg[3]; end
            MQ_Q1:   begin mq_a = cos_reg[2]; mq_b = sin_reg[3]; end
            MQ_DOT0: begin mq_a = vp0_reg;    mq_b = vq0_reg;    end
            MQ_DOT1: begin mq_a = vp1_reg;    mq_b = vq1_reg;    end
            MQ_DOT2: begin mq_a = sin_reg[0]; mq_b = sin_reg[2]; end
            default: begin mq_a = acos_c_reg; mq_b = acos_c_reg; end
        endcase
        mq_ua  = mq_a[63] ? 64'd0 - $unsigned(mq_a) : $unsigned(mq_a);
        mq_ub  = mq_b[63] ? 64'd0 - $unsigned(mq_b) : $unsigned(mq_b);
        mq_mag = (mul_prod[127:124] != 4'd0) ? {64{1'b1}} : mul_prod[123:60];
        if (mq_mag[63]) mq_mag = {1'b0, {63{1'b1}}};
        mq_res = (mq_a[63] != mq_b[63]) ? -$signed(mq_mag) : $signed(mq_mag);
    end

    assign rad_q     = $signed(div_quot[63:0]);
    assign s_val     = $signed({2'b00, sqrt_root, 30'd0});
    assign radius_mm = 34'(radius_reg) * 34'(MM_PER_M);
    assign dist_sum  = mul_prod + (128'd1 << 59);
    assign elapsed   = cur_time_reg - prev_time_reg;
    assign sqrt_in   = $unsigned(Q60_ONE - cc_reg);

    always_comb begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        have_prev_next = have_prev_reg;
        cur_lat_next   = cur_lat_reg;
        cur_lon_next   = cur_lon_reg;
        cur_time_next  = cur_time_reg;
        ang_idx_next   = ang_idx_reg;
        trem_next      = trem_reg;
        qd_next        = qd_reg;
        m_next         = m_reg;
        esign_next     = esign_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        vp0_next       = vp0_reg;
        vp1_next       = vp1_reg;
        vq0_next       = vq0_reg;
        vq1_next       = vq1_reg;
        dot_next       = dot_reg;
        acos_c_next    = acos_c_reg;
        cc_next        = cc_reg;
        theta_next     = theta_reg;
        mq_next        = mq_reg;
        status_next    = status_reg;
        dist_next      = dist_reg;
        speed_next     = speed_reg;
        out_load       = 1'b0;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        sqrt_start     = 1'b0;
        cor_cmd        = '0;
        cor_x0         = '0;
        cor_y0         = '0;
        cor_z0         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_lat_next  = $signed(s_latitude);
                    cur_lon_next  = $signed(s_longitude);
                    cur_time_next = s_timestamp_ns;
                    if (have_prev_reg) begin
                        ang_idx_next = 2'd0;
                        state_next   = ST_WRAP;
                    end else begin
                        status_next = STATUS_FIRST;
                        dist_next   = '0;
                        speed_next  = '0;
                        state_next  = ST_FINISH;
                    end
                end
            end
            ST_WRAP: begin
                trem_next  = ang_t[32:0];
                qd_next    = '0;
                state_next = ST_QUAD;
            end
            ST_QUAD: begin
                if (trem_reg >= QUARTER_TURN[32:0]) begin
                    trem_next = trem_reg - QUARTER_TURN[32:0];
                    qd_next   = qd_reg + 3'd1;
                end else begin
                    m_next     = ang_e_abs[28:0];
                    esign_next = ang_e[35];
                    state_next = ST_RAD_MUL;
                end
            end
            ST_RAD_MUL: begin
                mul_a = {35'd0, m_reg};
                mul_b = $unsigned(PI_Q60);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_RAD_DIV;
                end
            end
            ST_RAD_DIV: begin
                div_num = mul_prod[95:0];
                div_den = 64'(HALF_TURN);
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_ROT;
                end
            end
            ST_ROT: begin
                cor_x0 = GAIN_K;
                cor_y0 = '0;
                cor_z0 = esign_reg ? -rad_q : rad_q;
                if (!issued_reg) begin
                    cor_cmd.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (cor_done) begin
                    issued_next = 1'b0;
                    case (qd_reg[1:0])
                        2'd0: begin
                            cos_next[ang_idx_reg] = cor_x;
                            sin_next[ang_idx_reg] = cor_y;
                        end
                        2'd1: begin
                            cos_next[ang_idx_reg] = -cor_y;
                            sin_next[ang_idx_reg] = cor_x;
                        end
                        2'd2: begin
                            cos_next[ang_idx_reg] = -cor_x;
                            sin_next[ang_idx_reg] = -cor_y;
                        end
                        default: begin
                            cos_next[ang_idx_reg] = cor_y;
                            sin_next[ang_idx_reg] = -cor_x;
                        end
                    endcase
                    if (ang_idx_reg == 2'd3) begin
                        mq_next    = MQ_P0;
                        state_next = ST_MQ;
                    end else begin
                        ang_idx_next = ang_idx_reg + 2'd1;
                        state_next   = ST_WRAP;
                    end
                end
            end
            ST_MQ: begin
                mul_a = mq_ua;
                mul_b = mq_ub;
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    mq_next     = mq_step_t'(mq_reg + 3'd1);
                    case (mq_reg)
                        MQ_P0:   vp0_next = mq_res;
                        MQ_P1:   vp1_next = mq_res;
                        MQ_Q0:   vq0_next = mq_res;
                        MQ_Q1:   vq1_next = mq_res;
                        MQ_DOT0: dot_next = mq_res;
                        MQ_DOT1: dot_next = dot_reg + mq_res;
                        MQ_DOT2: begin
                            dot_next   = dot_reg + mq_res;
                            state_next = ST_CLAMP;
                        end
                        default: begin
                            cc_next    = mq_res;
                            state_next = ST_SQRT;
                        end
                    endcase
                end
            end
            ST_CLAMP: begin
                if (dot_reg > Q60_ONE)       acos_c_next = Q60_ONE;
                else if (dot_reg < -Q60_ONE) acos_c_next = -Q60_ONE;
                else                         acos_c_next = dot_reg;
                mq_next    = MQ_SQR;
                state_next = ST_MQ;
            end
            ST_SQRT: begin
                if (!issued_reg) begin
                    sqrt_start  = 1'b1;
                    issued_next = 1'b1;
                end else if (sqrt_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_VEC;
                end
            end
            ST_VEC: begin
                cor_cmd.vectoring = 1'b1;
                if (!acos_c_reg[63]) begin
                    cor_x0 = acos_c_reg;
                    cor_y0 = s_val;
                    cor_z0 = '0;
                end else begin
                    cor_x0 = s_val;
                    cor_y0 = -acos_c_reg;
                    cor_z0 = HALF_PI_Q60;
                end
                if (!issued_reg) begin
                    cor_cmd.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (cor_done) begin
                    issued_next = 1'b0;
                    if (cor_z[63])          theta_next = '0;
                    else if (cor_z > PI_Q60) theta_next = PI_Q60;
                    else                    theta_next = cor_z;
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                mul_a = {30'd0, radius_mm};
                mul_b = $unsigned(theta_reg);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    // round half up, then saturate
                    dist_next   = (dist_sum[127:95] != 33'd0) ? DIST_MAX : dist_sum[94:60];
                    state_next  = ST_TIME;
                end
            end
            ST_TIME: begin
                if (cur_time_reg > prev_time_reg) begin
                    state_next = ST_SPD_MUL;
                end else begin
                    status_next = STATUS_STALE;
                    speed_next  = '0;
                    state_next  = ST_FINISH;
                end
            end
            ST_SPD_MUL: begin
                mul_a = {29'd0, dist_reg};
                mul_b = {34'd0, NS_PER_S};
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_SPD_DIV;
                end
            end
            ST_SPD_DIV: begin
                div_num = mul_prod[95:0];
                div_den = {1'b0, elapsed};
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    issued_next = 1'b0;
                    speed_next  = (div_quot[95:32] != 64'd0) ? {32{1'b1}} : div_quot[31:0];
                    status_next = STATUS_OK;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register has room
                if (!m_valid_reg || m_ready) begin
                    out_load       = 1'b1;
                    have_prev_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = out_load | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            radius_reg    <= RADIUS_RESET;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            have_prev_reg <= have_prev_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) radius_reg <= cfg_sphere_radius_m;
        end
    end

    always_ff @(posedge aclk) begin
        cur_lat_reg  <= cur_lat_next;
        cur_lon_reg  <= cur_lon_next;
        cur_time_reg <= cur_time_next;
        ang_idx_reg  <= ang_idx_next;
        trem_reg     <= trem_next;
        qd_reg       <= qd_next;
        m_reg        <= m_next;
        esign_reg    <= esign_next;
        cos_reg      <= cos_next;
        sin_reg      <= sin_next;
        vp0_reg      <= vp0_next;
        vp1_reg      <= vp1_next;
        vq0_reg      <= vq0_next;
        vq1_reg      <= vq1_next;
        dot_reg      <= dot_next;
        acos_c_reg   <= acos_c_next;
        cc_reg       <= cc_next;
        theta_reg    <= theta_next;
        mq_reg       <= mq_next;
        status_reg   <= status_next;
        dist_reg     <= dist_next;
        speed_reg    <= speed_next;
        if (out_load) begin
            prev_lat_reg  <= cur_lat_reg;
            prev_lon_reg  <= cur_lon_reg;
            prev_time_reg <= cur_time_reg;
            m_status_reg  <= status_reg;
            m_dist_reg    <= dist_reg;
            m_speed_reg   <= speed_reg;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_distance_mm    = m_dist_reg;
    assign m_speed_mm_per_s = m_speed_reg;

    `ASSERT_IMPL(a_load_has_room, out_load, (!m_valid_reg || m_ready))
    `ASSERT_NEXT(a_busy_after_accept, (s_valid && s_ready), !s_ready)
    `ASSERT_NEXT(a_prev_after_load, out_load, have_prev_reg)
endmodule
